// ===== hw/rtl/larst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// larst_pkg
// Shared types and codes of the lazy affine range-sum tree unit.
// ----------------------------------------------------------------------------
package larst_pkg;

    localparam int DATA_W   = 64;
    localparam int CNT_W    = 11;
    localparam int IDX_W    = 10;
    localparam int OPC_W    = 2;
    localparam int DP_OP_W  = 5;

    localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

    // item opcodes
    localparam logic [OPC_W-1:0] OPC_LOAD   = 2'd0;
    localparam logic [OPC_W-1:0] OPC_BUILD  = 2'd1;
    localparam logic [OPC_W-1:0] OPC_UPDATE = 2'd2;
    localparam logic [OPC_W-1:0] OPC_QUERY  = 2'd3;

    // datapath commands
    localparam logic [DP_OP_W-1:0] DP_NOP      = 5'd0;
    localparam logic [DP_OP_W-1:0] DP_CLR_ALL  = 5'd1;
    localparam logic [DP_OP_W-1:0] DP_CLR_TAG  = 5'd2;
    localparam logic [DP_OP_W-1:0] DP_START    = 5'd3;
    localparam logic [DP_OP_W-1:0] DP_READ     = 5'd4;
    localparam logic [DP_OP_W-1:0] DP_LATCH    = 5'd5;
    localparam logic [DP_OP_W-1:0] DP_BLEAF    = 5'd6;
    localparam logic [DP_OP_W-1:0] DP_DESCEND  = 5'd7;
    localparam logic [DP_OP_W-1:0] DP_RET_SUM  = 5'd8;
    localparam logic [DP_OP_W-1:0] DP_ACC      = 5'd9;
    localparam logic [DP_OP_W-1:0] DP_TAG_IN   = 5'd10;
    localparam logic [DP_OP_W-1:0] DP_MUL_SS   = 5'd11;
    localparam logic [DP_OP_W-1:0] DP_MUL_OL   = 5'd12;
    localparam logic [DP_OP_W-1:0] DP_PSUM     = 5'd13;
    localparam logic [DP_OP_W-1:0] DP_CRD      = 5'd14;
    localparam logic [DP_OP_W-1:0] DP_CMUL1    = 5'd15;
    localparam logic [DP_OP_W-1:0] DP_CMUL2    = 5'd16;
    localparam logic [DP_OP_W-1:0] DP_CWR      = 5'd17;
    localparam logic [DP_OP_W-1:0] DP_RIGHT    = 5'd18;
    localparam logic [DP_OP_W-1:0] DP_POP      = 5'd19;
    localparam logic [DP_OP_W-1:0] DP_OUT      = 5'd20;

    typedef struct packed {
        logic [DP_OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic [OPC_W-1:0] opc;
        logic             in_range;
        logic             leaf;
        logic             mark;
        logic             disjoint;
        logic             full;
        logic             stk_empty;
        logic             top_phase;
        logic             csel;
        logic             clr_last;
        logic             out_busy;
    } t_sts;

    // pending tag: scale and offset only mean something while mark is set
    typedef struct packed {
        logic              mark;
        logic [DATA_W-1:0] scale;
        logic [DATA_W-1:0] offset;
    } t_tag;

endpackage
`default_nettype wire

// ===== hw/rtl/larst_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// larst_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module larst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/larst_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// larst_ctrl
// Sequencer: clearing passes, tree walk, lazy push and result hand-off.
// ----------------------------------------------------------------------------
module larst_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire larst_pkg::t_sts i_sts,
    output larst_pkg::t_cmd      o_cmd
);

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DISP   = 5'd2;
    localparam logic [4:0] S_BCLR   = 5'd3;
    localparam logic [4:0] S_VISIT  = 5'd4;
    localparam logic [4:0] S_LATCH  = 5'd5;
    localparam logic [4:0] S_DECIDE = 5'd6;
    localparam logic [4:0] S_CHECK  = 5'd7;
    localparam logic [4:0] S_P1     = 5'd8;
    localparam logic [4:0] S_P2     = 5'd9;
    localparam logic [4:0] S_P3     = 5'd10;
    localparam logic [4:0] S_CRD    = 5'd11;
    localparam logic [4:0] S_CLAT   = 5'd12;
    localparam logic [4:0] S_C2     = 5'd13;
    localparam logic [4:0] S_C3     = 5'd14;
    localparam logic [4:0] S_FIN    = 5'd15;
    localparam logic [4:0] S_RET    = 5'd16;
    localparam logic [4:0] S_OUT    = 5'd17;

    logic [4:0] r_state, n_state;
    logic       r_after, n_after;   // 1: push finishes a covered update
    logic [4:0] after_state;

    assign after_state = r_after ? S_FIN : S_CHECK;
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_after  = r_after;
        o_cmd.op = larst_pkg::DP_NOP;
        case (r_state)
            S_CLR: begin
                o_cmd.op = larst_pkg::DP_CLR_ALL;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = larst_pkg::DP_START;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.opc)
                    larst_pkg::OPC_LOAD:   n_state = S_IDLE;
                    larst_pkg::OPC_BUILD:  n_state = S_BCLR;
                    larst_pkg::OPC_UPDATE: n_state = i_sts.in_range ? S_VISIT : S_IDLE;
                    default:               n_state = i_sts.in_range ? S_VISIT : S_OUT;
                endcase
            end
            S_BCLR: begin
                o_cmd.op = larst_pkg::DP_CLR_TAG;
                if (i_sts.clr_last) n_state = S_VISIT;
            end
            S_VISIT: begin
                o_cmd.op = larst_pkg::DP_READ;
                n_state  = S_LATCH;
            end
            S_LATCH: begin
                o_cmd.op = larst_pkg::DP_LATCH;
                n_state  = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.opc == larst_pkg::OPC_BUILD) begin
                    if (i_sts.leaf) begin
                        o_cmd.op = larst_pkg::DP_BLEAF;
                        n_state  = S_RET;
                    end else begin
                        o_cmd.op = larst_pkg::DP_DESCEND;
                        n_state  = S_VISIT;
                    end
                end else if (i_sts.mark) begin
                    n_after = 1'b0;
                    n_state = S_P1;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.disjoint) begin
                    o_cmd.op = larst_pkg::DP_RET_SUM;
                    n_state  = S_RET;
                end else if (i_sts.full) begin
                    if (i_sts.opc == larst_pkg::OPC_QUERY) begin
                        o_cmd.op = larst_pkg::DP_ACC;
                        n_state  = S_RET;
                    end else begin
                        o_cmd.op = larst_pkg::DP_TAG_IN;
                        n_after  = 1'b1;
                        n_state  = S_P1;
                    end
                end else begin
                    o_cmd.op = larst_pkg::DP_DESCEND;
                    n_state  = S_VISIT;
                end
            end
            S_P1: begin
                o_cmd.op = larst_pkg::DP_MUL_SS;
                n_state  = S_P2;
            end
            S_P2: begin
                o_cmd.op = larst_pkg::DP_MUL_OL;
                n_state  = S_P3;
            end
            S_P3: begin
                o_cmd.op = larst_pkg::DP_PSUM;
                n_state  = i_sts.leaf ? after_state : S_CRD;
            end
            S_CRD: begin
                o_cmd.op = larst_pkg::DP_CRD;
                n_state  = S_CLAT;
            end
            S_CLAT: begin
                o_cmd.op = larst_pkg::DP_CMUL1;
                n_state  = S_C2;
            end
            S_C2: begin
                o_cmd.op = larst_pkg::DP_CMUL2;
                n_state  = S_C3;
            end
            S_C3: begin
                o_cmd.op = larst_pkg::DP_CWR;
                n_state  = i_sts.csel ? after_state : S_CRD;
            end
            S_FIN: begin
                o_cmd.op = larst_pkg::DP_RET_SUM;
                n_state  = S_RET;
            end
            S_RET: begin
                if (i_sts.stk_empty) begin
                    n_state = (i_sts.opc == larst_pkg::OPC_QUERY) ? S_OUT : S_IDLE;
                end else if (i_sts.top_phase) begin
                    o_cmd.op = larst_pkg::DP_POP;
                end else begin
                    o_cmd.op = larst_pkg::DP_RIGHT;
                    n_state  = S_VISIT;
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = larst_pkg::DP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_after <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/larst_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// larst_dp
// Datapath: node, tag and leaf stores, walk stack, shared multiplier.
// ----------------------------------------------------------------------------
module larst_dp #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [larst_pkg::CNT_W-1:0]        i_cfg_wdata,
    input  wire logic [larst_pkg::OPC_W-1:0]        i_opcode,
    input  wire logic [larst_pkg::IDX_W-1:0]        i_range_left,
    input  wire logic [larst_pkg::IDX_W-1:0]        i_range_right,
    input  wire logic signed [larst_pkg::DATA_W-1:0] i_load_value,
    input  wire logic signed [larst_pkg::DATA_W-1:0] i_scale_factor,
    input  wire logic signed [larst_pkg::DATA_W-1:0] i_offset_term,
    input  wire larst_pkg::t_cmd                    i_cmd,
    output larst_pkg::t_sts                         o_sts,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic signed [larst_pkg::DATA_W-1:0]     o_range_sum
);

    localparam int IW  = $clog2(MAX_ELEMENTS);
    localparam int ND  = 4 * MAX_ELEMENTS;
    localparam int NW  = $clog2(ND);
    localparam int SD  = IW + 1;
    localparam int SIW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);
    localparam int CW  = IW + larst_pkg::IDX_W + 1;
    localparam int DW  = larst_pkg::DATA_W;
    localparam int TW  = $bits(larst_pkg::t_tag);

    typedef struct packed {
        logic [NW-1:0] node;
        logic [IW-1:0] lo;
        logic [IW-1:0] hi;
        logic          phase;
        logic [DW-1:0] lsum;
    } t_frame;

    logic [larst_pkg::CNT_W-1:0] r_count;
    logic [larst_pkg::OPC_W-1:0] r_opc;
    logic [larst_pkg::IDX_W-1:0] r_left, r_right;
    logic [DW-1:0]               r_scale, r_offset;
    logic [NW-1:0]               r_node;
    logic [IW-1:0]               r_lo, r_hi;
    logic [SPW-1:0]              r_sp;
    t_frame                      r_stack [SD];
    logic [DW-1:0]               r_sum, r_ts, r_to, r_ret, r_acc, r_prod1, r_co;
    logic                        r_mark, r_cm, r_csel;
    logic [DW-1:0]               r_pp0;
    logic [31:0]                 r_pp1, r_pp2;
    logic [NW-1:0]               r_clr;
    logic                        r_out_valid;
    logic [DW-1:0]               r_out;

    logic [31:0]    cnt_eff;
    logic [IW-1:0]  root_hi;
    logic [IW:0]    lh_sum, top_lh_sum;
    logic [IW-1:0]  mid, top_mid;
    logic [SPW-1:0] sp_m1;
    t_frame         top;
    logic [NW-1:0]  child;
    logic           clr_last;
    logic [DW-1:0]  ma, mb, mul_res, len, psum, pop_sum;
    larst_pkg::t_tag tag_rd, cwr_tag;
    logic [TW-1:0]  tag_rd_raw;
    logic [DW-1:0]  sum_rd, leaf_rd;

    logic           sum_we, tag_we, tag_re, leaf_we;
    logic [NW-1:0]  sum_waddr, tag_waddr, tag_raddr;
    logic [DW-1:0]  sum_wdata, leaf_wdata;
    logic [TW-1:0]  tag_wdata;
    logic [IW-1:0]  leaf_waddr;

    // element count as the tree sees it
    always_comb begin
        if (r_count == '0) begin
            cnt_eff = 32'd1;
        end else if (32'(r_count) > 32'(MAX_ELEMENTS)) begin
            cnt_eff = 32'(MAX_ELEMENTS);
        end else begin
            cnt_eff = 32'(r_count);
        end
    end
    assign root_hi = IW'(cnt_eff - 32'd1);

    assign lh_sum     = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid        = lh_sum[IW:1];
    assign sp_m1      = r_sp - SPW'(1);
    assign top        = r_stack[sp_m1[SIW-1:0]];
    assign top_lh_sum = {1'b0, top.lo} + {1'b0, top.hi};
    assign top_mid    = top_lh_sum[IW:1];
    assign child      = {r_node[NW-2:0], r_csel};
    assign clr_last   = (r_clr == NW'(ND - 1));

    assign tag_rd = larst_pkg::t_tag'(tag_rd_raw);

    // 64x64 low product from three 32x32 partial products
    always_comb begin
        case (i_cmd.op)
            larst_pkg::DP_MUL_SS: begin
                ma = r_ts;
                mb = r_sum;
            end
            larst_pkg::DP_MUL_OL: begin
                ma = r_to;
                mb = len;
            end
            larst_pkg::DP_CMUL1: begin
                ma = tag_rd.scale;
                mb = r_ts;
            end
            default: begin
                ma = r_ts;
                mb = r_co;
            end
        endcase
    end
    assign mul_res = r_pp0 + {r_pp1 + r_pp2, 32'h0};

    assign len     = DW'(r_hi) - DW'(r_lo) + DW'(1);
    assign psum    = r_prod1 + mul_res;
    assign pop_sum = top.lsum + r_ret;

    always_comb begin
        cwr_tag.mark   = 1'b1;
        cwr_tag.scale  = r_cm ? r_prod1 : r_ts;
        cwr_tag.offset = r_cm ? (mul_res + r_to) : r_to;
    end

    // store ports
    always_comb begin
        sum_we     = 1'b0;
        sum_waddr  = r_node;
        sum_wdata  = r_sum;
        tag_we     = 1'b0;
        tag_waddr  = r_node;
        tag_wdata  = '0;
        tag_re     = 1'b0;
        tag_raddr  = r_node;
        leaf_we    = 1'b0;
        leaf_waddr = IW'(i_range_left);
        leaf_wdata = i_load_value;
        case (i_cmd.op)
            larst_pkg::DP_CLR_ALL: begin
                tag_we     = 1'b1;
                tag_waddr  = r_clr;
                leaf_we    = (32'(r_clr) < 32'(MAX_ELEMENTS));
                leaf_waddr = IW'(r_clr);
                leaf_wdata = '0;
            end
            larst_pkg::DP_CLR_TAG: begin
                tag_we    = 1'b1;
                tag_waddr = r_clr;
            end
            larst_pkg::DP_START: begin
                leaf_we = (i_opcode == larst_pkg::OPC_LOAD)
                          && (32'(i_range_left) < 32'(MAX_ELEMENTS));
            end
            larst_pkg::DP_READ: begin
                tag_re = 1'b1;
            end
            larst_pkg::DP_BLEAF: begin
                sum_we = 1'b1;
            end
            larst_pkg::DP_PSUM: begin
                sum_we    = 1'b1;
                sum_wdata = psum;
                tag_we    = 1'b1;
            end
            larst_pkg::DP_CRD: begin
                tag_re    = 1'b1;
                tag_raddr = child;
            end
            larst_pkg::DP_CWR: begin
                tag_we    = 1'b1;
                tag_waddr = child;
                tag_wdata = cwr_tag;
            end
            larst_pkg::DP_POP: begin
                sum_we    = (r_opc != larst_pkg::OPC_QUERY);
                sum_waddr = top.node;
                sum_wdata = pop_sum;
            end
            default: begin
                sum_we = 1'b0;
            end
        endcase
    end

    larst_ram #(.WIDTH(DW), .DEPTH(ND)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_re    (i_cmd.op == larst_pkg::DP_READ),
        .i_raddr (r_node),
        .o_rdata (sum_rd)
    );

    larst_ram #(.WIDTH(TW), .DEPTH(ND)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_re    (tag_re),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rd_raw)
    );

    larst_ram #(.WIDTH(DW), .DEPTH(MAX_ELEMENTS)) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (leaf_we),
        .i_waddr (leaf_waddr),
        .i_wdata (leaf_wdata),
        .i_re    (i_cmd.op == larst_pkg::DP_READ),
        .i_raddr (r_lo),
        .o_rdata (leaf_rd)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= larst_pkg::COUNT_RESET;
            r_sp        <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_count <= i_cfg_wdata;
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (i_cmd.op)
                larst_pkg::DP_CLR_ALL,
                larst_pkg::DP_CLR_TAG: r_clr <= clr_last ? '0 : r_clr + NW'(1);
                larst_pkg::DP_START:   r_sp  <= '0;
                larst_pkg::DP_DESCEND: r_sp  <= r_sp + SPW'(1);
                larst_pkg::DP_POP:     r_sp  <= sp_m1;
                larst_pkg::DP_OUT:     r_out_valid <= 1'b1;
                default:               r_sp  <= r_sp;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pp0 <= ma[31:0] * mb[31:0];
        r_pp1 <= 32'(ma[31:0] * mb[63:32]);
        r_pp2 <= 32'(ma[63:32] * mb[31:0]);
        case (i_cmd.op)
            larst_pkg::DP_START: begin
                r_opc    <= i_opcode;
                r_left   <= i_range_left;
                r_right  <= i_range_right;
                r_scale  <= i_scale_factor;
                r_offset <= i_offset_term;
                r_node   <= NW'(1);
                r_lo     <= '0;
                r_hi     <= root_hi;
                r_acc    <= '0;
            end
            larst_pkg::DP_LATCH: begin
                r_sum  <= (r_opc == larst_pkg::OPC_BUILD) ? leaf_rd : sum_rd;
                r_mark <= tag_rd.mark;
                r_ts   <= tag_rd.scale;
                r_to   <= tag_rd.offset;
            end
            larst_pkg::DP_BLEAF,
            larst_pkg::DP_RET_SUM: r_ret <= r_sum;
            larst_pkg::DP_DESCEND: begin
                r_stack[r_sp[SIW-1:0]] <= '{node: r_node, lo: r_lo, hi: r_hi,
                                            phase: 1'b0, lsum: '0};
                r_node <= {r_node[NW-2:0], 1'b0};
                r_hi   <= mid;
            end
            larst_pkg::DP_RIGHT: begin
                r_stack[sp_m1[SIW-1:0]].phase <= 1'b1;
                r_stack[sp_m1[SIW-1:0]].lsum  <= r_ret;
                r_node <= {top.node[NW-2:0], 1'b1};
                r_lo   <= top_mid + IW'(1);
                r_hi   <= top.hi;
            end
            larst_pkg::DP_ACC: r_acc <= r_acc + r_sum;
            larst_pkg::DP_TAG_IN: begin
                r_ts <= r_scale;
                r_to <= r_offset;
            end
            larst_pkg::DP_MUL_OL,
            larst_pkg::DP_CMUL2: r_prod1 <= mul_res;
            larst_pkg::DP_PSUM: begin
                r_sum  <= psum;
                r_csel <= 1'b0;
            end
            larst_pkg::DP_CMUL1: begin
                r_co <= tag_rd.offset;
                r_cm <= tag_rd.mark;
            end
            larst_pkg::DP_CWR: r_csel <= ~r_csel;
            larst_pkg::DP_POP: r_ret  <= pop_sum;
            larst_pkg::DP_OUT: r_out  <= r_acc;
            default: r_ret <= r_ret;
        endcase
    end

    always_comb begin
        o_sts.opc       = r_opc;
        o_sts.in_range  = (r_left <= r_right);
        o_sts.leaf      = (r_lo == r_hi);
        o_sts.mark      = r_mark;
        o_sts.disjoint  = (CW'(r_right) < CW'(r_lo)) || (CW'(r_left) > CW'(r_hi));
        o_sts.full      = (CW'(r_left) <= CW'(r_lo)) && (CW'(r_hi) <= CW'(r_right));
        o_sts.stk_empty = (r_sp == '0);
        o_sts.top_phase = top.phase;
        o_sts.csel      = r_csel;
        o_sts.clr_last  = clr_last;
        o_sts.out_busy  = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_range_sum = r_out;

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_sp) <= 32'(SD))
        else $error("walk stack overflow");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == larst_pkg::DP_OUT) |-> !r_out_valid)
        else $error("result loaded over a pending word");

    a_out_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == larst_pkg::DP_OUT) |=> r_out_valid)
        else $error("result not presented");

    a_descend_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == larst_pkg::DP_DESCEND) |-> (r_lo != r_hi))
        else $error("descend from a leaf");

endmodule
`default_nettype wire

// ===== hw/rtl/lazy_affine_range_sum_tree_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lazy_affine_range_sum_tree_unit
// Segment tree with lazy affine range updates and wrapped range sums.
// ----------------------------------------------------------------------------
//  channel | signals                               | moves
//  --------+---------------------------------------+--------------------------
//  in      | i_in_valid / o_in_ready               | one item word
//  out     | o_out_valid / i_out_ready             | one range_sum word
//  cfg     | i_cfg_we / i_cfg_wdata                | element_count, no stall
//
//  Reset: a clearing pass over all 4*MAX_ELEMENTS tag entries clears the
//  pending marks and the leaf buffer; no item is taken until it ends.
//  Build: tag clearing over all 4*MAX_ELEMENTS entries, then a pass over
//  every tree node. Update and query: a walk over the visited nodes, where
//  each lazy push on an inner node updates the sum and two child tags and
//  on a leaf the sum only, all through one shared 64-bit low-product
//  multiplier. The tree memories' single ports set the per-node cost.
//  A finished result sits in the output register; the next item is taken
//  meanwhile, and only another query waits for that register to drain.
// ----------------------------------------------------------------------------
module lazy_affine_range_sum_tree_unit #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [larst_pkg::CNT_W-1:0]         i_cfg_wdata,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [larst_pkg::OPC_W-1:0]         i_opcode,
    input  wire logic [larst_pkg::IDX_W-1:0]         i_range_left,
    input  wire logic [larst_pkg::IDX_W-1:0]         i_range_right,
    input  wire logic signed [larst_pkg::DATA_W-1:0] i_load_value,
    input  wire logic signed [larst_pkg::DATA_W-1:0] i_scale_factor,
    input  wire logic signed [larst_pkg::DATA_W-1:0] i_offset_term,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [larst_pkg::DATA_W-1:0]      o_range_sum
);

    // controller only steers; all values live in the datapath
    larst_pkg::t_cmd cmd;
    larst_pkg::t_sts sts;

    larst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    larst_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_opcode       (i_opcode),
        .i_range_left   (i_range_left),
        .i_range_right  (i_range_right),
        .i_load_value   (i_load_value),
        .i_scale_factor (i_scale_factor),
        .i_offset_term  (i_offset_term),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_range_sum    (o_range_sum)
    );

endmodule
`default_nettype wire

// ===== sim/larst_sum_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// larst_sum_checker
// Watches the item, config and result channels of the range-sum tree unit.
// Keeps its own lazy affine segment tree, predicts every range sum and
// compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module larst_sum_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [larst_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_ready,
    input  wire logic [larst_pkg::OPC_W-1:0]  i_opcode,
    input  wire logic [larst_pkg::IDX_W-1:0]  i_range_left,
    input  wire logic [larst_pkg::IDX_W-1:0]  i_range_right,
    input  wire logic [larst_pkg::DATA_W-1:0] i_load_value,
    input  wire logic [larst_pkg::DATA_W-1:0] i_scale_factor,
    input  wire logic [larst_pkg::DATA_W-1:0] i_offset_term,
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_ready,
    input  wire logic [larst_pkg::DATA_W-1:0] i_range_sum,
    output int                                o_fail_count,
    output int                                o_sums_pending
);

    localparam int LEAVES = 1024;
    localparam int NODES  = 4 * LEAVES;
    localparam int DW     = larst_pkg::DATA_W;

    logic [DW-1:0]               tree_sum   [NODES];
    logic [DW-1:0]               tag_scale  [NODES];
    logic [DW-1:0]               tag_offset [NODES];
    logic                        tag_mark   [NODES];
    logic [DW-1:0]               leaf_val   [LEAVES];
    logic [larst_pkg::CNT_W-1:0] elem_count;
    logic [DW-1:0]               sum_expect_q [$];

    function automatic void reset_tags();
        for (int i = 0; i < NODES; i++) begin
            tag_scale[i]  = 64'd1;
            tag_offset[i] = 64'd0;
            tag_mark[i]   = 1'b0;
        end
    endfunction

    function automatic int span_count();
        if (elem_count == 0) return 1;
        if (elem_count > LEAVES) return LEAVES;
        return int'(elem_count);
    endfunction

    function automatic void compose_tag(int nd, logic [DW-1:0] s, logic [DW-1:0] o);
        tag_scale[nd]  = tag_scale[nd] * s;
        tag_offset[nd] = s * tag_offset[nd] + o;
    endfunction

    function automatic void apply_tag(int nd, int lo, int hi);
        logic [DW-1:0] s;
        logic [DW-1:0] o;
        s = tag_scale[nd];
        o = tag_offset[nd];
        tree_sum[nd] = s * tree_sum[nd] + o * 64'(hi - lo + 1);
        if (lo != hi) begin
            compose_tag(2 * nd, s, o);
            compose_tag(2 * nd + 1, s, o);
            tag_mark[2 * nd]     = 1'b1;
            tag_mark[2 * nd + 1] = 1'b1;
        end
        tag_mark[nd]   = 1'b0;
        tag_scale[nd]  = 64'd1;
        tag_offset[nd] = 64'd0;
    endfunction

    function automatic void build_tree(int nd, int lo, int hi);
        int mid;
        if (lo == hi) begin
            tree_sum[nd] = leaf_val[lo];
            return;
        end
        mid = (lo + hi) / 2;
        build_tree(2 * nd, lo, mid);
        build_tree(2 * nd + 1, mid + 1, hi);
        tree_sum[nd] = tree_sum[2 * nd] + tree_sum[2 * nd + 1];
    endfunction

    function automatic logic [DW-1:0] sum_range(int nd, int lo, int hi, int l, int r);
        int mid;
        if (tag_mark[nd]) apply_tag(nd, lo, hi);
        if (r < lo || l > hi) return 64'd0;
        if (l <= lo && hi <= r) return tree_sum[nd];
        mid = (lo + hi) / 2;
        return sum_range(2 * nd, lo, mid, l, r) + sum_range(2 * nd + 1, mid + 1, hi, l, r);
    endfunction

    function automatic void affine_range(int nd, int lo, int hi, int l, int r,
                                         logic [DW-1:0] s, logic [DW-1:0] o);
        int mid;
        if (tag_mark[nd]) apply_tag(nd, lo, hi);
        if (r < lo || l > hi) return;
        if (l <= lo && hi <= r) begin
            compose_tag(nd, s, o);
            apply_tag(nd, lo, hi);
            return;
        end
        mid = (lo + hi) / 2;
        affine_range(2 * nd, lo, mid, l, r, s, o);
        affine_range(2 * nd + 1, mid + 1, hi, l, r, s, o);
        tree_sum[nd] = tree_sum[2 * nd] + tree_sum[2 * nd + 1];
    endfunction

    initial begin
        for (int i = 0; i < NODES; i++) tree_sum[i] = '0;
        for (int i = 0; i < LEAVES; i++) leaf_val[i] = '0;
        reset_tags();
        elem_count = larst_pkg::COUNT_RESET;
    end

    always @(posedge i_clk) begin
        int n;
        int l;
        int r;
        logic [DW-1:0] want;
        if (!i_rst_n) begin
            o_fail_count   = 0;
            o_sums_pending = 0;
        end else begin
            // result side first: any word leaving now belongs to an older query
            if (i_out_valid && i_out_ready) begin
                if (sum_expect_q.size() == 0) begin
                    $display("%0t unexpected range_sum word: actual %h", $time, i_range_sum);
                    o_fail_count++;
                end else begin
                    want = sum_expect_q.pop_front();
                    if (i_range_sum !== want) begin
                        $display("%0t range_sum mismatch: expected %h actual %h",
                                 $time, want, i_range_sum);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) elem_count = i_cfg_wdata;
            if (i_in_valid && i_in_ready) begin
                n = span_count();
                l = int'(i_range_left);
                r = int'(i_range_right);
                case (i_opcode)
                    larst_pkg::OPC_LOAD: leaf_val[l] = i_load_value;
                    larst_pkg::OPC_BUILD: begin
                        reset_tags();
                        build_tree(1, 0, n - 1);
                    end
                    larst_pkg::OPC_UPDATE: begin
                        if (l <= r)
                            affine_range(1, 0, n - 1, l, r, i_scale_factor, i_offset_term);
                    end
                    default: begin
                        sum_expect_q.push_back((l <= r) ? sum_range(1, 0, n - 1, l, r)
                                                        : 64'd0);
                    end
                endcase
            end
            o_sums_pending = sum_expect_q.size();
        end
    end

endmodule

// ===== sim/lazy_affine_range_sum_tree_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lazy_affine_range_sum_tree_unit_tb
// Drives load, build, affine update and range sum words into the tree unit
// under random gaps and back-pressure, across several element counts, and
// lets the checker score every range sum.
// ----------------------------------------------------------------------------
module lazy_affine_range_sum_tree_unit_tb;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 3000;
    localparam int CNT_W       = larst_pkg::CNT_W;
    localparam int OPC_W       = larst_pkg::OPC_W;
    localparam int IDX_W       = larst_pkg::IDX_W;
    localparam int DATA_W      = larst_pkg::DATA_W;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wdata = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [OPC_W-1:0]  i_opcode = larst_pkg::OPC_LOAD;
    logic [IDX_W-1:0]  i_range_left = '0;
    logic [IDX_W-1:0]  i_range_right = '0;
    logic [DATA_W-1:0] i_load_value = '0;
    logic [DATA_W-1:0] i_scale_factor = '0;
    logic [DATA_W-1:0] i_offset_term = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [DATA_W-1:0] o_range_sum;

    int  fail_count;
    int  sums_pending;
    int  cycle_count = 0;
    int  cur_count = 1024;      // live element count, as the block sees it
    bit  no_gaps = 1'b0;        // stretches with no idling on either side
    bit  hold_rx = 1'b0;        // long receiver hold-off
    bit  start_hold = 1'b0;
    int  rx_wait = 0;

    always #4 i_clk = ~i_clk;

    lazy_affine_range_sum_tree_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_range_left   (i_range_left),
        .i_range_right  (i_range_right),
        .i_load_value   (i_load_value),
        .i_scale_factor (i_scale_factor),
        .i_offset_term  (i_offset_term),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_range_sum    (o_range_sum)
    );

    larst_sum_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_range_left   (i_range_left),
        .i_range_right  (i_range_right),
        .i_load_value   (i_load_value),
        .i_scale_factor (i_scale_factor),
        .i_offset_term  (i_offset_term),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_range_sum    (o_range_sum),
        .o_fail_count   (fail_count),
        .o_sums_pending (sums_pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lazy_affine_range_sum_tree_unit_tb: FAIL");
            $finish;
        end
    end

    function automatic int gap_draw();
        return no_gaps ? 0 : $urandom_range(0, 10);
    endfunction

    // receiver: random stalls per word, plus the long hold-off when asked
    always @(posedge i_clk) begin
        if (i_out_ready && o_out_valid) rx_wait = gap_draw();
        if (hold_rx || rx_wait > 0) begin
            i_out_ready <= 1'b0;
            if (rx_wait > 0) rx_wait--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // the hold-off counts its own cycles; the sender keeps offering words
    initial begin
        wait (start_hold);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    function automatic logic [DATA_W-1:0] value_draw();
        case ($urandom_range(0, 7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return {64{1'b1}};
            3: return 64'(signed'($urandom_range(0, 16)) - 8);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // one word on the item channel; valid is only lowered when a gap follows
    task automatic send_word(input logic [OPC_W-1:0] opc, input int l, input int r,
                             input logic [DATA_W-1:0] lv, input logic [DATA_W-1:0] sf,
                             input logic [DATA_W-1:0] ot);
        int gap;
        gap = gap_draw();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= opc;
        i_range_left   <= IDX_W'(l);
        i_range_right  <= IDX_W'(r);
        i_load_value   <= lv;
        i_scale_factor <= sf;
        i_offset_term  <= ot;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic random_word();
        int l;
        int r;
        int pick;
        logic [OPC_W-1:0] opc;
        pick = $urandom_range(0, 99);
        if (pick < 20) opc = larst_pkg::OPC_LOAD;
        else if (pick < 24) opc = larst_pkg::OPC_BUILD;
        else if (pick < 60) opc = larst_pkg::OPC_UPDATE;
        else opc = larst_pkg::OPC_QUERY;
        case ($urandom_range(0, 9))
            0: begin                            // empty range
                r = $urandom_range(0, 1022);
                l = $urandom_range(r + 1, 1023);
            end
            1: begin                            // any bits at all
                l = $urandom_range(0, 1023);
                r = $urandom_range(0, 1023);
            end
            2: begin                            // reaching past the elements
                l = $urandom_range(0, cur_count - 1);
                r = $urandom_range(l, 1023);
            end
            default: begin
                l = $urandom_range(0, cur_count - 1);
                r = $urandom_range(l, cur_count - 1);
            end
        endcase
        if (opc == larst_pkg::OPC_LOAD && $urandom_range(0, 1)) l = $urandom_range(0, 1023);
        send_word(opc, l, r, value_draw(), value_draw(), value_draw());
    endtask

    // block must be idle: every sum has come back, and each phase ends in a query
    task automatic set_count(input logic [CNT_W-1:0] cnt);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sums_pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cnt;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_count = (cnt == 0) ? 1 : (cnt > 1024) ? 1024 : int'(cnt);
    endtask

    localparam logic [DATA_W-1:0] S_MIN = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] S_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    initial begin
        logic [CNT_W-1:0] phase_cnt [8];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every opcode and empty ranges
        set_count(11'd1024);
        send_word(larst_pkg::OPC_LOAD, 0, 0, S_MAX, 0, 0);
        send_word(larst_pkg::OPC_LOAD, 1023, 0, S_MIN, 0, 0);
        send_word(larst_pkg::OPC_LOAD, 512, 0, {64{1'b1}}, 0, 0);
        send_word(larst_pkg::OPC_LOAD, 341, 0, 64'h5555_5555_5555_5555, 0, 0);
        send_word(larst_pkg::OPC_LOAD, 682, 0, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0);
        send_word(larst_pkg::OPC_BUILD, 0, 0, 0, 0, 0);
        send_word(larst_pkg::OPC_QUERY, 0, 1023, 0, 0, 0);
        send_word(larst_pkg::OPC_QUERY, 0, 0, 0, 0, 0);
        send_word(larst_pkg::OPC_QUERY, 1023, 1023, 0, 0, 0);
        send_word(larst_pkg::OPC_UPDATE, 0, 1023, 0, {64{1'b1}}, S_MAX);
        send_word(larst_pkg::OPC_QUERY, 5, 1000, 0, 0, 0);
        send_word(larst_pkg::OPC_UPDATE, 10, 3, 0, S_MIN, S_MIN);
        send_word(larst_pkg::OPC_QUERY, 900, 2, 0, 0, 0);
        send_word(larst_pkg::OPC_UPDATE, 3, 3, 0, 0, 7);
        send_word(larst_pkg::OPC_UPDATE, 2, 700, 0, S_MIN, 1);
        send_word(larst_pkg::OPC_QUERY, 0, 3, 0, 0, 0);
        send_word(larst_pkg::OPC_QUERY, 1000, 1023, 0, 0, 0);
        send_word(larst_pkg::OPC_QUERY, 511, 513, 0, 0, 0);

        // later counts: the first one walks the held tree without a rebuild;
        // zero is taken as one and anything past 1024 as 1024
        phase_cnt = '{11'd300, 11'd0, 11'd2047, 11'd1, 11'd2,
                      11'($urandom_range(3, 1023)), 11'd1024, 11'd1025};
        for (int p = 0; p < 8; p++) begin
            set_count(phase_cnt[p]);
            no_gaps = (p == 2 || p == 5);
            if (p == 3) start_hold = 1'b1;
            for (int k = 0; k < 55; k++) begin
                if (p == 3 && k < 20)
                    send_word(larst_pkg::OPC_QUERY, 0, $urandom_range(0, 1023), 0, 0, 0);
                else
                    random_word();
            end
            send_word(larst_pkg::OPC_QUERY, 0, 1023, 0, 0, 0);
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        while (sums_pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("lazy_affine_range_sum_tree_unit_tb: PASS");
        end else begin
            $display("lazy_affine_range_sum_tree_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/larst_pkg.sv
hw/rtl/larst_ram.sv
hw/rtl/larst_ctrl.sv
hw/rtl/larst_dp.sv
hw/rtl/lazy_affine_range_sum_tree_unit.sv
sim/larst_sum_checker.sv
sim/lazy_affine_range_sum_tree_unit_tb.sv
